@@ hw/rtl/assert_macros.svh @@
// --------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and reset-qualified
// --------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dbd_pkg.sv @@
// --------------------------------------------------------------------------
// dbd_pkg
// shared types, opcodes and widths of the delayed bucket distributor
// --------------------------------------------------------------------------
package dbd_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int NUM_BUCKETS_DEF = 16;
  localparam int ITEM_WIDTH_DEF  = 64;

  localparam int OP_W       = 2;
  localparam int DATA_W     = 64;
  localparam int BUCKET_W   = 4;
  localparam int PTR_W      = 32;
  localparam int S_TDATA_W  = 136;
  localparam int M_TDATA_W  = 96;
  localparam int M_TUSER_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_LOAD  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    logic rd_en;   // read the oldest entry (after this cycle's pop)
    logic pop;     // retire the oldest entry
    logic push;    // store a new entry
    logic clear;   // empty the ring
  } ring_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } ring_stat_t;

  typedef struct packed {
    logic [PTR_W-1:0] ptr;
    logic [PTR_W-1:0] limit;
  } bkt_entry_t;

endpackage

@@ hw/rtl/delayed_bucket_distributor_core.sv @@
// --------------------------------------------------------------------------
// delayed_bucket_distributor_core
// push into a ring with room goes through the emit state; push into a full ring
// reads the ring, reads the bucket table and writes it back; load and clear finish in idle
// flush: each drained word takes a ring read, then the bucket table
// read-modify-write of its entry; an empty flush goes through the emit state
// reset: a sweep over all buckets zeroes the bucket table, no input taken then
// --------------------------------------------------------------------------
`include "assert_macros.svh"

module delayed_bucket_distributor_core import dbd_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int ITEM_WIDTH  = ITEM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // item_data [63:0], bucket [67:64], bucket_start [99:68], bucket_end [131:100]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // opcode [1:0]
  input  logic [OP_W-1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // write_slot [31:0], write_data [95:32]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // write_valid [0], room_left [1], drained [2]
  output logic [M_TUSER_W-1:0] m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int BKT_AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RING = 4'b0010,
    ST_BKT  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  op_t                   s_op;
  logic [BKT_AW-1:0]     s_bkt;
  logic                  accept;
  logic                  out_free;

  op_t                   op_q;
  logic [ITEM_WIDTH-1:0] data_q;
  logic [BKT_AW-1:0]     bkt_q;

  ring_cmd_t             ring_cmd;
  ring_stat_t            ring_stat;
  logic [ITEM_WIDTH-1:0] ring_rd_data;
  logic [BKT_AW-1:0]     ring_rd_dest;

  logic                  bkt_rd_en;
  bkt_entry_t            bkt_rd;
  logic                  bkt_wr_en;
  logic [BKT_AW-1:0]     bkt_wr_addr;
  bkt_entry_t            bkt_wr;
  logic                  bkt_busy;

  logic [PTR_W-1:0]      new_ptr;
  logic                  below;
  logic                  stop;

  logic                  load_out;
  logic                  out_valid;
  logic                  res_wvalid, res_wvalid_next;
  logic [PTR_W-1:0]      res_slot, res_slot_next;
  logic [DATA_W-1:0]     res_data, res_data_next;
  logic                  res_room, res_room_next;
  logic                  res_drained, res_drained_next;
  logic                  res_last, res_last_next;
  logic                  rd_issue;

  assign s_op  = op_t'(s_axis_tuser);
  assign s_bkt = BKT_AW'(32'(s_axis_tdata[67:64]) % NUM_BUCKETS);

  assign s_axis_tready = (state == ST_IDLE) && !bkt_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  assign new_ptr = bkt_rd.ptr + 1'b1;
  assign below   = new_ptr < bkt_rd.limit;
  // flush stops once a bucket hits its limit or the ring runs dry
  assign stop    = !below || ring_stat.single;

  always_comb begin
    state_next       = state;
    ring_cmd         = '0;
    bkt_rd_en        = 1'b0;
    bkt_wr_en        = 1'b0;
    bkt_wr_addr      = ring_rd_dest;
    bkt_wr           = '{ptr: new_ptr, limit: bkt_rd.limit};
    load_out         = 1'b0;
    res_wvalid_next  = 1'b0;
    res_slot_next    = '0;
    res_data_next    = '0;
    res_room_next    = 1'b0;
    res_drained_next = 1'b0;
    res_last_next    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_op)
            OP_PUSH: begin
              if (ring_stat.full) begin
                ring_cmd.rd_en = 1'b1;
                state_next     = ST_RING;
              end else begin
                state_next = ST_EMIT;
              end
            end
            OP_FLUSH: begin
              if (ring_stat.empty) begin
                state_next = ST_EMIT;
              end else begin
                ring_cmd.rd_en = 1'b1;
                state_next     = ST_RING;
              end
            end
            OP_LOAD: begin
              bkt_wr_en   = 1'b1;
              bkt_wr_addr = s_bkt;
              bkt_wr      = '{ptr: s_axis_tdata[99:68], limit: s_axis_tdata[131:100]};
            end
            OP_CLEAR: begin
              ring_cmd.clear = 1'b1;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_RING: begin
        bkt_rd_en  = 1'b1;
        state_next = ST_BKT;
      end
      ST_BKT: begin
        if (out_free) begin
          load_out        = 1'b1;
          bkt_wr_en       = 1'b1;
          ring_cmd.pop    = 1'b1;
          res_wvalid_next = 1'b1;
          res_slot_next   = bkt_rd.ptr;
          res_data_next   = DATA_W'(ring_rd_data);
          if (op_q == OP_PUSH) begin
            ring_cmd.push = 1'b1;
            res_room_next = below;
            state_next    = ST_IDLE;
          end else begin
            res_drained_next = ring_stat.single;
            res_last_next    = stop;
            if (stop) begin
              state_next = ST_IDLE;
            end else begin
              ring_cmd.rd_en = 1'b1;
              state_next     = ST_RING;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (op_q == OP_PUSH) begin
            ring_cmd.push = 1'b1;
            res_room_next = 1'b1;
          end else begin
            res_drained_next = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd_issue = ring_cmd.rd_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= s_op;
      data_q <= s_axis_tdata[ITEM_WIDTH-1:0];
      bkt_q  <= s_bkt;
    end
    if (load_out) begin
      res_wvalid  <= res_wvalid_next;
      res_slot    <= res_slot_next;
      res_data    <= res_data_next;
      res_room    <= res_room_next;
      res_drained <= res_drained_next;
      res_last    <= res_last_next;
    end
  end

  dbd_ring #(
    .CAPACITY    (CAPACITY),
    .NUM_BUCKETS (NUM_BUCKETS),
    .ITEM_WIDTH  (ITEM_WIDTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ring_cmd),
    .wr_data (data_q),
    .wr_dest (bkt_q),
    .rd_data (ring_rd_data),
    .rd_dest (ring_rd_dest),
    .stat    (ring_stat)
  );

  dbd_bucket_mem #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_bucket_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (bkt_rd_en),
    .rd_addr (ring_rd_dest),
    .rd_data (bkt_rd),
    .wr_en   (bkt_wr_en),
    .wr_addr (bkt_wr_addr),
    .wr_data (bkt_wr),
    .busy    (bkt_busy)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {res_data, res_slot};
  assign m_axis_tuser  = {res_drained, res_room, res_wvalid};
  assign m_axis_tlast  = res_last;

  `ASSERT_IMPL(a_ring_data_ready, clk, rst, state == ST_RING, $past(rd_issue), "ring data used without a read")

endmodule

@@ hw/rtl/dbd_ring.sv @@
// --------------------------------------------------------------------------
// dbd_ring
// holding ring: payload and destination memory with push and drain counts
// --------------------------------------------------------------------------
`include "assert_macros.svh"

module dbd_ring import dbd_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int ITEM_WIDTH  = ITEM_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ring_cmd_t              cmd,
  input  logic [ITEM_WIDTH-1:0]  wr_data,
  input  logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] wr_dest,
  output logic [ITEM_WIDTH-1:0]  rd_data,
  output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] rd_dest,
  output ring_stat_t             stat
);

  localparam int BKT_AW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int RING_AW = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(2 * CAPACITY);
  localparam int OCC_W   = CNT_W + 1;
  localparam int CNT_MAX = 2 * CAPACITY - 1;

  logic [ITEM_WIDTH-1:0] payload_mem [CAPACITY];
  logic [BKT_AW-1:0]     dest_mem    [CAPACITY];

  logic [CNT_W-1:0] push_count, push_count_next;
  logic [CNT_W-1:0] drain_count, drain_count_next;
  logic [OCC_W-1:0] occ;

  function automatic logic [RING_AW-1:0] idx_of(input logic [CNT_W-1:0] c);
    if (c >= CNT_W'(CAPACITY)) begin
      return RING_AW'(c - CNT_W'(CAPACITY));
    end else begin
      return RING_AW'(c);
    end
  endfunction

  function automatic logic [CNT_W-1:0] inc(input logic [CNT_W-1:0] c);
    if (c == CNT_W'(CNT_MAX)) begin
      return '0;
    end else begin
      return c + 1'b1;
    end
  endfunction

  // counts run modulo twice the depth so full and empty stay apart
  always_comb begin
    if (push_count >= drain_count) begin
      occ = {1'b0, push_count} - {1'b0, drain_count};
    end else begin
      occ = {1'b0, push_count} + OCC_W'(2 * CAPACITY) - {1'b0, drain_count};
    end
  end

  assign stat.empty  = (push_count == drain_count);
  assign stat.full   = (occ == OCC_W'(CAPACITY));
  assign stat.single = (occ == OCC_W'(1));

  always_comb begin
    push_count_next  = push_count;
    drain_count_next = drain_count;
    if (cmd.clear) begin
      push_count_next  = '0;
      drain_count_next = '0;
    end else begin
      if (cmd.push) begin
        push_count_next = inc(push_count);
      end
      if (cmd.pop) begin
        drain_count_next = inc(drain_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push_count  <= '0;
      drain_count <= '0;
    end else begin
      push_count  <= push_count_next;
      drain_count <= drain_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      payload_mem[idx_of(push_count)] <= wr_data;
      dest_mem[idx_of(push_count)]    <= wr_dest;
    end
  end

  // read follows the pop of the same cycle, so the next oldest is fetched
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= payload_mem[idx_of(drain_count_next)];
      rd_dest <= dest_mem[idx_of(drain_count_next)];
    end
  end

  `ASSERT_ALWAYS(a_occ_bound, clk, rst, occ <= OCC_W'(CAPACITY), "ring occupancy above capacity")
  `ASSERT_IMPL(a_full_push_pops, clk, rst, cmd.push && stat.full, cmd.pop, "push into full ring without pop")
  `ASSERT_IMPL(a_no_pop_empty, clk, rst, cmd.pop, !stat.empty, "pop from empty ring")

endmodule

@@ hw/rtl/dbd_bucket_mem.sv @@
// --------------------------------------------------------------------------
// dbd_bucket_mem
// bucket pointer and limit table with a zeroing sweep after reset
// --------------------------------------------------------------------------
`include "assert_macros.svh"

module dbd_bucket_mem import dbd_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] rd_addr,
  output bkt_entry_t  rd_data,
  input  logic        wr_en,
  input  logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] wr_addr,
  input  bkt_entry_t  wr_data,
  output logic        busy
);

  localparam int BKT_AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [BKT_AW-1:0] LAST_IDX = BKT_AW'(NUM_BUCKETS - 1);

  bkt_entry_t        table_mem [NUM_BUCKETS];
  logic [BKT_AW-1:0] sweep_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      sweep_idx <= '0;
    end else if (busy) begin
      sweep_idx <= sweep_idx + 1'b1;
      if (sweep_idx == LAST_IDX) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      table_mem[sweep_idx] <= '0;
    end else if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  `ASSERT_IMPL(a_sweep_complete, clk, rst, $fell(busy), $past(sweep_idx) == LAST_IDX, "bucket sweep ended early")

endmodule

@@ tb/sv/delayed_bucket_distributor_core_test.sv @@
// --------------------------------------------------------------------------
// delayed_bucket_distributor_core_test
// pushes, flushes, bucket loads and ring clears go in on the slave stream;
// a scoreboard class keeps its own copy of the ring and the bucket tables,
// predicts every write word and checks the master stream against it
// --------------------------------------------------------------------------
module delayed_bucket_distributor_core_test;
  import dbd_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int BUCKETS     = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 48;

  typedef struct packed {
    logic              write_valid;
    logic [PTR_W-1:0]  write_slot;
    logic [DATA_W-1:0] write_data;
    logic              room_left;
    logic              drained;
    logic              last;
  } write_word_t;

  class bucket_write_scoreboard;
    logic [DATA_W-1:0]   held_data [RING_DEPTH];
    logic [BUCKET_W-1:0] held_bucket [RING_DEPTH];
    logic [4:0]          in_count;
    logic [4:0]          out_count;
    logic [PTR_W-1:0]    next_slot [BUCKETS];
    logic [PTR_W-1:0]    slot_limit [BUCKETS];
    write_word_t         pending_writes [$];
    int                  mismatches;

    function new();
      in_count   = '0;
      out_count  = '0;
      mismatches = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        held_data[i]   = '0;
        held_bucket[i] = '0;
      end
      for (int i = 0; i < BUCKETS; i++) begin
        next_slot[i]  = '0;
        slot_limit[i] = '0;
      end
    endfunction

    // counts run modulo twice the depth, so the difference is the fill level
    function int fill_level();
      logic [4:0] diff;
      diff = in_count - out_count;
      return int'(diff);
    endfunction

    function bit write_oldest_entry(output logic [PTR_W-1:0] slot,
                                    output logic [DATA_W-1:0] data);
      logic [3:0]          idx;
      logic [BUCKET_W-1:0] b;
      idx  = out_count[3:0];
      b    = held_bucket[idx];
      slot = next_slot[b];
      data = held_data[idx];
      next_slot[b] = next_slot[b] + 32'd1;
      out_count = out_count + 5'd1;
      return next_slot[b] < slot_limit[b];
    endfunction

    function void accept_word(op_t op, logic [DATA_W-1:0] data,
                              logic [BUCKET_W-1:0] bucket,
                              logic [PTR_W-1:0] start, logic [PTR_W-1:0] lim);
      write_word_t w;
      logic [3:0]  idx;
      bit          below;
      bit          stop;
      w = '0;
      case (op)
        OP_PUSH: begin
          w.room_left = 1'b1;
          w.last = 1'b1;
          if (fill_level() >= RING_DEPTH) begin
            w.room_left = write_oldest_entry(w.write_slot, w.write_data);
            w.write_valid = 1'b1;
          end
          idx = in_count[3:0];
          held_bucket[idx] = bucket;
          held_data[idx] = data;
          in_count = in_count + 5'd1;
          pending_writes.push_back(w);
        end
        OP_FLUSH: begin
          if (fill_level() == 0) begin
            w.drained = 1'b1;
            w.last = 1'b1;
            pending_writes.push_back(w);
          end else begin
            // stops right after a write that brings a bucket to its limit or empties the ring
            stop = 1'b0;
            while (!stop) begin
              w = '0;
              below = write_oldest_entry(w.write_slot, w.write_data);
              w.write_valid = 1'b1;
              stop = !below || fill_level() == 0;
              w.drained = stop && fill_level() == 0;
              w.last = stop;
              pending_writes.push_back(w);
            end
          end
        end
        OP_LOAD: begin
          next_slot[bucket]  = start;
          slot_limit[bucket] = lim;
        end
        default: begin
          in_count  = '0;
          out_count = '0;
        end
      endcase
    endfunction

    function void check_write(write_word_t got);
      write_word_t want;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: valid %0b slot %h data %h room %0b drained %0b last %0b",
                   got.write_valid, got.write_slot, got.write_data, got.room_left,
                   got.drained, got.last);
        return;
      end
      want = pending_writes.pop_front();
      if (got.write_valid !== want.write_valid || got.write_slot !== want.write_slot ||
          got.write_data !== want.write_data || got.room_left !== want.room_left ||
          got.drained !== want.drained || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: valid %0b slot %h data %h room %0b drained %0b last %0b",
                   want.write_valid, want.write_slot, want.write_data, want.room_left,
                   want.drained, want.last);
          $display("         got: valid %0b slot %h data %h room %0b drained %0b last %0b",
                   got.write_valid, got.write_slot, got.write_data, got.room_left,
                   got.drained, got.last);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // item_data [63:0], bucket [67:64], bucket_start [99:68], bucket_end [131:100]
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  // opcode [1:0]
  logic [OP_W-1:0]      s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // write_slot [31:0], write_data [95:32]
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // write_valid [0], room_left [1], drained [2]
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  bucket_write_scoreboard sb = new();
  int send_idle = 32;
  int recv_idle = 45;
  int cycle_count = 0;

  delayed_bucket_distributor_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // both handshakes sampled at the edge, before any driver update lands
  always @(posedge clk) begin
    write_word_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.write_valid = m_axis_tuser[0];
      got.room_left   = m_axis_tuser[1];
      got.drained     = m_axis_tuser[2];
      got.write_slot  = m_axis_tdata[31:0];
      got.write_data  = m_axis_tdata[95:32];
      got.last        = m_axis_tlast;
      sb.check_write(got);
    end
    if (s_axis_tvalid && s_axis_tready)
      sb.accept_word(op_t'(s_axis_tuser), s_axis_tdata[63:0], s_axis_tdata[67:64],
                     s_axis_tdata[99:68], s_axis_tdata[131:100]);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("delayed_bucket_distributor_core_test NOT OK");
      $finish;
    end
  end

  task automatic send_word(input op_t op, input logic [DATA_W-1:0] data,
                           input logic [BUCKET_W-1:0] bucket,
                           input logic [PTR_W-1:0] start, input logic [PTR_W-1:0] lim);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, lim, start, bucket, data};
    @(posedge clk);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
  endtask

  // hold off the sender until the master stream has caught up
  task automatic wait_all_writes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_word();
    int                  pick;
    logic [PTR_W-1:0]    start;
    logic [PTR_W-1:0]    lim;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_word(OP_PUSH, {$urandom, $urandom}, 4'($urandom_range(15)), $urandom, $urandom);
    end else if (pick < 82) begin
      send_word(OP_FLUSH, {$urandom, $urandom}, 4'($urandom_range(15)), $urandom, $urandom);
    end else if (pick < 97) begin
      case ($urandom_range(3))
        0:       start = $urandom_range(8);
        1:       start = 32'hFFFF_FFF0 + $urandom_range(15);
        default: start = $urandom;
      endcase
      case ($urandom_range(4))
        0:       lim = start;
        1:       lim = $urandom;
        default: lim = start + $urandom_range(1, 24);
      endcase
      send_word(OP_LOAD, {$urandom, $urandom}, 4'($urandom_range(15)), start, lim);
    end else begin
      send_word(OP_CLEAR, {$urandom, $urandom}, 4'($urandom_range(15)), $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty flush, pointer wrap, full ring, early flush stop
    send_word(OP_FLUSH, '0, '0, '0, '0);
    send_word(OP_LOAD, '1, 4'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(OP_LOAD, '0, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000);
    for (int i = 0; i < RING_DEPTH; i++) begin
      case (i)
        0:       send_word(OP_PUSH, 64'h0, 4'd0, '1, '1);
        1:       send_word(OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, '0, '0);
        2:       send_word(OP_PUSH, 64'h5555_5555_5555_5555, 4'd0, '0, '0);
        3:       send_word(OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 4'd15, '0, '0);
        default: send_word(OP_PUSH, {$urandom, $urandom}, (i % 2) ? 4'd15 : 4'd0,
                           $urandom, $urandom);
      endcase
    end
    send_word(OP_PUSH, {$urandom, $urandom}, 4'd7, '0, '0);
    send_word(OP_PUSH, {$urandom, $urandom}, 4'd9, '0, '0);
    send_word(OP_FLUSH, '0, '0, '0, '0);
    send_word(OP_CLEAR, '0, '0, '0, '0);
    send_word(OP_FLUSH, '0, '0, '0, '0);
    wait_all_writes();

    repeat (66) send_random_word();
    wait_all_writes();
    send_idle = 45;
    recv_idle = 32;
    repeat (66) send_random_word();
    send_idle = 0;
    recv_idle = 0;
    repeat (64) send_random_word();

    wait_all_writes();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending_writes.size() != 0)
      $display("%0d expected words never arrived", sb.pending_writes.size());
    if (sb.mismatches == 0 && sb.pending_writes.size() == 0)
      $display("delayed_bucket_distributor_core_test OK");
    else
      $display("delayed_bucket_distributor_core_test NOT OK");
    $finish;
  end

endmodule
